FILE: hdl/sis_pkg.sv
// Shared types for the stable insertion sorter: controller states and cell control.
package sis_pkg;

    typedef enum logic {
        ST_LOAD  = 1'b0,
        ST_DRAIN = 1'b1
    } t_state;

    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctrl;

endpackage

FILE: hdl/sis_cell.sv
// One storage cell of the sorting chain: holds one key and tag, compares, shifts.
module sis_cell
    import sis_pkg::*;
#(
    parameter int KEY_BITS = 32,
    parameter int TAG_BITS = 8
) (
    input  logic                       i_clk,
    input  t_cell_ctrl                 i_ctrl,
    input  logic signed [KEY_BITS-1:0] i_new_key,
    input  logic        [TAG_BITS-1:0] i_new_tag,
    input  logic                       i_occupied,
    input  logic signed [KEY_BITS-1:0] i_left_key,
    input  logic        [TAG_BITS-1:0] i_left_tag,
    input  logic                       i_left_greater,
    input  logic signed [KEY_BITS-1:0] i_right_key,
    input  logic        [TAG_BITS-1:0] i_right_tag,
    output logic signed [KEY_BITS-1:0] o_key,
    output logic        [TAG_BITS-1:0] o_tag,
    output logic                       o_greater
);

    logic signed [KEY_BITS-1:0] r_key;
    logic signed [KEY_BITS-1:0] n_key;
    logic        [TAG_BITS-1:0] r_tag;
    logic        [TAG_BITS-1:0] n_tag;

    // Strictly greater only, so an equal new key lands behind the stored one.
    assign o_greater = i_occupied && (r_key > i_new_key);

    always_comb begin
        n_key = r_key;
        n_tag = r_tag;
        priority if (i_ctrl.shift) begin
            n_key = i_right_key;
            n_tag = i_right_tag;
        end else if (i_ctrl.insert) begin
            priority if (i_left_greater) begin
                n_key = i_left_key;
                n_tag = i_left_tag;
            end else if (o_greater || !i_occupied) begin
                n_key = i_new_key;
                n_tag = i_new_tag;
            end else begin
                n_key = r_key;
                n_tag = r_tag;
            end
        end else begin
            n_key = r_key;
            n_tag = r_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
    end

    assign o_key = r_key;
    assign o_tag = r_tag;

endmodule

FILE: hdl/stable_insertion_sorter_top.sv
// Top level of the stable insertion sorter: cell chain, fill count and output stage.
//
//   Channel | Valid    | Stall    | Payload
//   --------+----------+----------+------------------------------------------------
//   input   | i_valid  | o_stall  | i_in_key, i_in_tag, i_in_last
//   output  | o_valid  | i_stall  | o_out_key, o_out_tag, o_out_final, o_out_overflow
//
// While a set is loading, one input beat is taken every cycle; each key is placed by the
// whole chain of compare-and-shift cells in the cycle it is accepted.
// The beat marked last moves the block into draining, which hands out the stored entries
// in order with the input stalled; the chain shifts toward cell 0.
// Output stalls pause draining; a finished result waits in the output register.
// Reset is synchronous and active low; it clears the count, the drop flag and the state.
module stable_insertion_sorter_top
    import sis_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32,
    parameter int TAG_BITS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [KEY_BITS-1:0] i_in_key,
    input  logic        [TAG_BITS-1:0] i_in_tag,
    input  logic                       i_in_last,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [KEY_BITS-1:0] o_out_key,
    output logic        [TAG_BITS-1:0] o_out_tag,
    output logic                       o_out_final,
    output logic                       o_out_overflow
);

    localparam int CW = $clog2(ENTRIES + 1);

    t_state           r_state;
    t_state           n_state;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             r_dropped;
    logic             n_dropped;
    logic             r_out_valid;
    logic             n_out_valid;
    logic signed [KEY_BITS-1:0] r_out_key;
    logic        [TAG_BITS-1:0] r_out_tag;
    logic             r_out_final;
    logic             r_out_overflow;

    logic             accept_in;
    logic             room;
    logic             load_out;
    logic             count_is_one;
    t_cell_ctrl       cell_ctrl;

    logic signed [KEY_BITS-1:0] w_key     [ENTRIES];
    logic        [TAG_BITS-1:0] w_tag     [ENTRIES];
    logic                       w_greater [ENTRIES];

    assign room         = (r_count != CW'(ENTRIES));
    assign count_is_one = (r_count == CW'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (i_valid && i_in_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (load_out && count_is_one) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // State decode: input handshake, cell commands and output loading.
    always_comb begin
        o_stall   = 1'b1;
        load_out  = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_stall = 1'b0;
            end
            ST_DRAIN: begin
                load_out = (!r_out_valid || !i_stall) && (r_count != '0);
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
        accept_in        = i_valid && !o_stall;
        cell_ctrl.insert = accept_in && room;
        cell_ctrl.shift  = load_out;
    end

    // Fill count, drop flag and output register control.
    always_comb begin
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_out_valid = r_out_valid;
        if (cell_ctrl.insert) begin
            n_count = r_count + CW'(1);
        end else if (load_out) begin
            n_count = r_count - CW'(1);
        end
        if (accept_in && !room) begin
            n_dropped = 1'b1;
        end else if (load_out && count_is_one) begin
            n_dropped = 1'b0;
        end
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    // The head cell always holds the smallest remaining entry while draining.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_key      <= w_key[0];
            r_out_tag      <= w_tag[0];
            r_out_final    <= count_is_one;
            r_out_overflow <= r_dropped;
        end
    end

    // The chain: a cell is occupied when its index is below the fill count. On insert,
    // every cell holding a larger key moves up one place and the new entry drops into
    // the gap; on drain, each cell but the tail takes its upper neighbor's contents.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic signed [KEY_BITS-1:0] left_key;
        logic        [TAG_BITS-1:0] left_tag;
        logic                       left_greater;
        logic signed [KEY_BITS-1:0] right_key;
        logic        [TAG_BITS-1:0] right_tag;

        if (g == 0) begin : g_head
            assign left_key     = '0;
            assign left_tag     = '0;
            assign left_greater = 1'b0;
        end else begin : g_body
            assign left_key     = w_key[g-1];
            assign left_tag     = w_tag[g-1];
            assign left_greater = w_greater[g-1];
        end

        if (g == ENTRIES - 1) begin : g_tail
            assign right_key = w_key[g];
            assign right_tag = w_tag[g];
        end else begin : g_inner
            assign right_key = w_key[g+1];
            assign right_tag = w_tag[g+1];
        end

        sis_cell #(
            .KEY_BITS(KEY_BITS),
            .TAG_BITS(TAG_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_ctrl         (cell_ctrl),
            .i_new_key      (i_in_key),
            .i_new_tag      (i_in_tag),
            .i_occupied     (CW'(g) < r_count),
            .i_left_key     (left_key),
            .i_left_tag     (left_tag),
            .i_left_greater (left_greater),
            .i_right_key    (right_key),
            .i_right_tag    (right_tag),
            .o_key          (w_key[g]),
            .o_tag          (w_tag[g]),
            .o_greater      (w_greater[g])
        );
    end

    assign o_valid        = r_out_valid;
    assign o_out_key      = r_out_key;
    assign o_out_tag      = r_out_tag;
    assign o_out_final    = r_out_final;
    assign o_out_overflow = r_out_overflow;

endmodule

FILE: hdl/sis_checker.sv
// Port-level assertions for the stable insertion sorter and their bind.
module sis_checker #(
    parameter int KEY_BITS = 32,
    parameter int TAG_BITS = 8
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       i_in_last,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic signed [KEY_BITS-1:0] o_out_key,
    input logic        [TAG_BITS-1:0] o_out_tag,
    input logic                       o_out_final,
    input logic                       o_out_overflow
);

    // A beat marked last starts draining, so the input stalls right after it.
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_in_last) |=> o_stall)
        else $error("input not stalled after last beat");

    // While a non-final result is shown, the run is still draining.
    a_run_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_final) |-> o_stall)
        else $error("input open in the middle of a run");

    // The overflow mark is the same on every beat of a run.
    a_overflow_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_out_final) |=>
        (!o_valid || (o_out_overflow == $past(o_out_overflow))))
        else $error("overflow mark changed within a run");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_key) && $stable(o_out_tag)))
        else $error("stalled result changed");

endmodule

bind stable_insertion_sorter_top sis_checker #(
    .KEY_BITS(KEY_BITS),
    .TAG_BITS(TAG_BITS)
) u_sis_checker (.*);

FILE: bench/stable_insertion_sorter_checker.sv
// Checker for the stable insertion sorter: watches both channels, predicts sorted runs, compares.
`timescale 1ns / 1ps

module stable_insertion_sorter_checker #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32,
    parameter int TAG_BITS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic signed [KEY_BITS-1:0] i_in_key,
    input  logic        [TAG_BITS-1:0] i_in_tag,
    input  logic                       i_in_last,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic signed [KEY_BITS-1:0] i_out_key,
    input  logic        [TAG_BITS-1:0] i_out_tag,
    input  logic                       i_out_final,
    input  logic                       i_out_overflow,
    output int                         o_mismatch_count,
    output int                         o_sorted_pending
);

    typedef struct packed {
        logic signed [KEY_BITS-1:0] key;
        logic        [TAG_BITS-1:0] tag;
        logic                       is_final;
        logic                       overflow;
    } t_sorted_entry;

    logic signed [KEY_BITS-1:0] held_key [ENTRIES];
    logic        [TAG_BITS-1:0] held_tag [ENTRIES];
    int                         held_count = 0;
    logic                       drop_seen  = 1'b0;
    t_sorted_entry              sorted_run_q [$];
    int                         mismatch_count = 0;

    assign o_mismatch_count = mismatch_count;

    // Every mismatch prints one line and is counted.
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : watch
        int            pos;
        int            k;
        t_sorted_entry entry;
        if (!i_rst_n) begin
            held_count = 0;
            drop_seen  = 1'b0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (sorted_run_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result key %h tag %h",
                                              i_out_key, i_out_tag));
                end else begin
                    entry = sorted_run_q.pop_front();
                    if (i_out_key !== entry.key)
                        report_mismatch($sformatf("key %h, expected %h", i_out_key, entry.key));
                    if (i_out_tag !== entry.tag)
                        report_mismatch($sformatf("tag %h, expected %h (key %h)",
                                                  i_out_tag, entry.tag, entry.key));
                    if (i_out_final !== entry.is_final)
                        report_mismatch($sformatf("final mark %b, expected %b (key %h)",
                                                  i_out_final, entry.is_final, entry.key));
                    if (i_out_overflow !== entry.overflow)
                        report_mismatch($sformatf("overflow %b, expected %b (key %h)",
                                                  i_out_overflow, entry.overflow, entry.key));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                // Insert after every equal key so that ties keep arrival order.
                if (held_count < ENTRIES) begin
                    pos = held_count;
                    while (pos > 0 && held_key[pos-1] > i_in_key) begin
                        held_key[pos] = held_key[pos-1];
                        held_tag[pos] = held_tag[pos-1];
                        pos--;
                    end
                    held_key[pos] = i_in_key;
                    held_tag[pos] = i_in_tag;
                    held_count++;
                end else begin
                    drop_seen = 1'b1;
                end
                if (i_in_last) begin
                    for (k = 0; k < held_count; k++) begin
                        entry.key      = held_key[k];
                        entry.tag      = held_tag[k];
                        entry.is_final = (k == held_count - 1);
                        entry.overflow = drop_seen;
                        sorted_run_q.push_back(entry);
                    end
                    held_count = 0;
                    drop_seen  = 1'b0;
                end
            end
        end
        o_sorted_pending <= sorted_run_q.size();
    end

endmodule

FILE: bench/stable_insertion_sorter_top_test.sv
// Testbench top for the stable insertion sorter: clock, reset, stimulus, output stalls, verdict.
`timescale 1ns / 1ps

module stable_insertion_sorter_top_test;

    localparam int ENTRIES      = 16;
    localparam int KEY_BITS     = 32;
    localparam int TAG_BITS     = 8;
    localparam int RANDOM_ITEMS = 350;
    // This limit sits far above what the slowest correct run needs, leaving wide margin.
    localparam int CYCLE_LIMIT  = 400000;
    // Extra wait for the drain and output stalls before the verdict.
    localparam int DRAIN_MARGIN = 64;

    typedef struct {
        logic signed [KEY_BITS-1:0] key;
        logic        [TAG_BITS-1:0] tag;
        logic                       last;
    } t_input_beat;

    // Key styles for a random set: wide random keys, a small pool that forces many ties,
    // the signed extremes plus zero and -1, and a falling sequence that mostly shifts the chain.
    typedef enum int {
        KEYS_WIDE,
        KEYS_TIED,
        KEYS_EDGE,
        KEYS_FALLING
    } t_key_style;

    logic                       i_clk     = 1'b0;
    logic                       i_rst_n   = 1'b0;
    logic                       i_valid   = 1'b0;
    logic signed [KEY_BITS-1:0] i_in_key  = '0;
    logic        [TAG_BITS-1:0] i_in_tag  = '0;
    logic                       i_in_last = 1'b0;
    logic                       i_stall   = 1'b0;
    logic                       o_stall;
    logic                       o_valid;
    logic signed [KEY_BITS-1:0] o_out_key;
    logic        [TAG_BITS-1:0] o_out_tag;
    logic                       o_out_final;
    logic                       o_out_overflow;
    int                         mismatch_count;
    int                         sorted_pending;
    int                         cycle_count = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    stable_insertion_sorter_top #(
        .ENTRIES (ENTRIES),
        .KEY_BITS(KEY_BITS),
        .TAG_BITS(TAG_BITS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_in_key      (i_in_key),
        .i_in_tag      (i_in_tag),
        .i_in_last     (i_in_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_key     (o_out_key),
        .o_out_tag     (o_out_tag),
        .o_out_final   (o_out_final),
        .o_out_overflow(o_out_overflow)
    );

    // The checker sits beside the block on the same wires and owns all prediction.
    stable_insertion_sorter_checker #(
        .ENTRIES (ENTRIES),
        .KEY_BITS(KEY_BITS),
        .TAG_BITS(TAG_BITS)
    ) i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_in_key        (i_in_key),
        .i_in_tag        (i_in_tag),
        .i_in_last       (i_in_last),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_out_key       (o_out_key),
        .i_out_tag       (o_out_tag),
        .i_out_final     (o_out_final),
        .i_out_overflow  (o_out_overflow),
        .o_mismatch_count(mismatch_count),
        .o_sorted_pending(sorted_pending)
    );

    // Gap before an input beat: mostly none, often short, now and then a long one.
    function automatic int next_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) return 0;
        if (pick < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Drives one beat and returns at the edge where it is taken. Valid is only lowered
    // when a gap is wanted, so back-to-back beats keep it high without a glitch.
    task automatic send_beat(input t_input_beat beat, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_key  <= beat.key;
        i_in_tag  <= beat.tag;
        i_in_last <= beat.last;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Output stalls: short bursts, a few long ones, and quiet stretches with none at all,
    // so stalls land on the first, middle and final result of a drain alike.
    always @(posedge i_clk) begin : stall_gen
        static int stall_left = 0;
        static int quiet_left = 0;
        int        pick;
        if (stall_left > 0) begin
            stall_left--;
        end else if (quiet_left > 0) begin
            quiet_left--;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                quiet_left = $urandom_range(50, 200);
            end else if (pick < 24) begin
                stall_left = $urandom_range(1, 3);
            end else if (pick < 27) begin
                stall_left = $urandom_range(8, 30);
            end
        end
        i_stall <= (stall_left > 0);
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        t_input_beat                directed_q [$];
        t_input_beat                beat;
        t_key_style                 key_style;
        logic signed [KEY_BITS-1:0] key_pool [4];
        logic signed [KEY_BITS-1:0] falling_key;
        int                         random_sent;
        int                         set_size;
        int                         i;
        int                         j;
        bit                         calm_set;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A set of one, holding the largest key and the largest tag.
        directed_q.push_back('{32'sh7fff_ffff, 8'hff, 1'b1});
        // Both signed extremes, minus one, and a run of equal zero keys whose tags must
        // come out in arrival order; the tie closing the set is the beat marked last.
        directed_q.push_back('{32'sh8000_0000, 8'h00, 1'b0});
        directed_q.push_back('{32'sh0000_0000, 8'h0f, 1'b0});
        directed_q.push_back('{32'sh7fff_ffff, 8'hf0, 1'b0});
        directed_q.push_back('{32'sh0000_0000, 8'h10, 1'b0});
        directed_q.push_back('{-32'sd1,        8'haa, 1'b0});
        directed_q.push_back('{32'sh0000_0000, 8'h55, 1'b1});
        // Seventeen falling Q16.16 keys: the store fills, and the beat marked last is
        // itself dropped, yet the full run must still come out flagged as overflowed.
        for (i = 0; i < ENTRIES + 1; i++) begin
            directed_q.push_back('{(KEY_BITS'(ENTRIES - i) <<< 16) - 32'sh0000_8000,
                                   TAG_BITS'(i), (i == ENTRIES)});
        end
        foreach (directed_q[i]) begin
            send_beat(directed_q[i], next_gap());
        end

        // Random sets: mostly partial fills, some exactly full, some overflowing.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            j = $urandom_range(0, 9);
            if (j == 0) begin
                set_size = $urandom_range(ENTRIES + 1, ENTRIES + 4);
            end else if (j == 1) begin
                set_size = ENTRIES;
            end else if (j < 5) begin
                set_size = $urandom_range(1, 3);
            end else begin
                set_size = $urandom_range(4, ENTRIES - 1);
            end
            key_style = t_key_style'($urandom_range(0, 3));
            calm_set  = ($urandom_range(0, 3) == 0);
            foreach (key_pool[j]) key_pool[j] = $urandom;
            falling_key = $urandom;
            for (i = 0; i < set_size; i++) begin
                case (key_style)
                    KEYS_WIDE: begin
                        beat.key = $urandom;
                    end
                    KEYS_TIED: begin
                        beat.key = key_pool[$urandom_range(0, 3)];
                    end
                    KEYS_EDGE: begin
                        case ($urandom_range(0, 4))
                            0:       beat.key = 32'sh8000_0000;
                            1:       beat.key = 32'sh7fff_ffff;
                            2:       beat.key = '0;
                            3:       beat.key = -32'sd1;
                            default: beat.key = $urandom;
                        endcase
                    end
                    default: begin
                        falling_key = falling_key - KEY_BITS'($urandom_range(0, 70000));
                        beat.key    = falling_key;
                    end
                endcase
                beat.tag  = TAG_BITS'($urandom);
                beat.last = (i == set_size - 1);
                send_beat(beat, calm_set ? 0 : next_gap());
                random_sent++;
            end
        end
        i_valid <= 1'b0;

        // One edge first so the checker has counted the final set before we poll it.
        @(posedge i_clk);
        while (sorted_pending != 0) @(posedge i_clk);
        repeat (DRAIN_MARGIN) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/sis_pkg.sv
hdl/sis_cell.sv
hdl/stable_insertion_sorter_top.sv
hdl/sis_checker.sv
bench/stable_insertion_sorter_checker.sv
bench/stable_insertion_sorter_top_test.sv
